FILE: design/tpq_pkg.sv
// Shared types, constants and calibration functions for the touch press qualifier.
package tpq_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 12;
  localparam int PRESS_W    = 13;
  localparam int TIME_W     = 32;
  localparam int GAP_W      = 16;
  localparam int RUN_W      = 8;
  localparam int POS_X_W    = 9;
  localparam int POS_Y_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_HIGH      = 2'd0,
    REG_RELEASE_LOW     = 2'd1,
    REG_RELEASE_SAMPLES = 2'd2,
    REG_FIRE_GAP        = 2'd3
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [PRESS_W-1:0] PRESS_HIGH_RST      = 13'd220;
  localparam logic [PRESS_W-1:0] RELEASE_LOW_RST     = 13'd90;
  localparam logic [RUN_W-1:0]   RELEASE_SAMPLES_RST = 8'd3;
  localparam logic [GAP_W-1:0]   FIRE_GAP_RST        = 16'd200;

  // Pressure is z1 plus full scale minus z2.
  localparam logic [PRESS_W-1:0] PRESS_FULL_SCALE = 13'd4095;
  localparam logic [RUN_W-1:0]   RUN_MAX          = 8'd255;

  // Column calibration: (avg_y - 465) * 320 / 3075, clamped to 319.
  // The divide is a multiply by ceil(2^22 * 64 / 615), exact for any 12-bit offset value.
  localparam logic [SAMPLE_W-1:0] COL_OFF   = 12'd465;
  localparam logic [18:0]         COL_MULT  = 19'd436481;
  localparam int                  COL_SHIFT = 22;
  localparam logic [POS_X_W-1:0]  COL_MAX   = 9'd319;

  // Row calibration: (avg_x - 620) * 240 / 2660, clamped to 239.
  // The divide is a multiply by ceil(2^20 * 12 / 133), exact for any 12-bit offset value.
  localparam logic [SAMPLE_W-1:0] ROW_OFF   = 12'd620;
  localparam logic [16:0]         ROW_MULT  = 17'd94609;
  localparam int                  ROW_SHIFT = 20;
  localparam logic [POS_Y_W-1:0]  ROW_MAX   = 8'd239;

  // Configuration bundle.
  typedef struct packed {
    logic [PRESS_W-1:0] press_high;
    logic [PRESS_W-1:0] release_low;
    logic [RUN_W-1:0]   release_samples;
    logic [GAP_W-1:0]   fire_gap_ms;
  } cfg_t;

  // One sample set; the last member sits in the lowest bits.
  typedef struct packed {
    logic [TIME_W-1:0]   time_ms;
    logic [SAMPLE_W-1:0] raw_y_d;
    logic [SAMPLE_W-1:0] raw_y_c;
    logic [SAMPLE_W-1:0] raw_y_b;
    logic [SAMPLE_W-1:0] raw_y_a;
    logic [SAMPLE_W-1:0] raw_x_d;
    logic [SAMPLE_W-1:0] raw_x_c;
    logic [SAMPLE_W-1:0] raw_x_b;
    logic [SAMPLE_W-1:0] raw_x_a;
    logic [SAMPLE_W-1:0] pressure_two;
    logic [SAMPLE_W-1:0] pressure_one;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic               fired;
    logic [PRESS_W-1:0] pressure;
    logic               in_contact;
    logic [POS_Y_W-1:0] pos_y;
    logic [POS_X_W-1:0] pos_x;
  } res_t;

  // Screen column from the averaged Y sample.
  function automatic logic [POS_X_W-1:0] map_col(input logic [SAMPLE_W-1:0] avg);
    logic [SAMPLE_W-1:0] diff;
    logic [30:0]         prod;
    logic [POS_X_W-1:0]  quo;
    diff = avg - COL_OFF;
    prod = 31'(diff) * 31'(COL_MULT);
    quo  = prod[COL_SHIFT +: POS_X_W];
    if (avg <= COL_OFF) begin
      return '0;
    end else if (quo > COL_MAX) begin
      return COL_MAX;
    end
    return quo;
  endfunction

  // Screen row from the averaged X sample.
  function automatic logic [POS_Y_W-1:0] map_row(input logic [SAMPLE_W-1:0] avg);
    logic [SAMPLE_W-1:0] diff;
    logic [28:0]         prod;
    logic [8:0]          quo;
    diff = avg - ROW_OFF;
    prod = 29'(diff) * 29'(ROW_MULT);
    quo  = prod[ROW_SHIFT +: 9];
    if (avg <= ROW_OFF) begin
      return '0;
    end else if (quo > 9'(ROW_MAX)) begin
      return ROW_MAX;
    end
    return quo[POS_Y_W-1:0];
  endfunction

endpackage

FILE: design/tpq_cfg_regs.sv
// Configuration register file of the touch press qualifier.
module tpq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpq_pkg::CFG_DATA_W-1:0] cfg_data,
  output tpq_pkg::cfg_t                  cfg
);
  import tpq_pkg::*;

  // Write decode; each register keeps its low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_high      <= PRESS_HIGH_RST;
      cfg.release_low     <= RELEASE_LOW_RST;
      cfg.release_samples <= RELEASE_SAMPLES_RST;
      cfg.fire_gap_ms     <= FIRE_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRESS_HIGH:      cfg.press_high      <= cfg_data[PRESS_W-1:0];
        REG_RELEASE_LOW:     cfg.release_low     <= cfg_data[PRESS_W-1:0];
        REG_RELEASE_SAMPLES: cfg.release_samples <= cfg_data[RUN_W-1:0];
        REG_FIRE_GAP:        cfg.fire_gap_ms     <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/tpq_qualify.sv
// Per-sample pressure, press latch, release debounce and coordinate mapping.
module tpq_qualify (
  input  logic              clk,
  input  logic              rst,
  input  tpq_pkg::cfg_t     cfg,
  input  tpq_pkg::in_item_t item,
  input  logic              advance,
  output tpq_pkg::res_t     res
);
  import tpq_pkg::*;

  logic                press_latched;
  logic [RUN_W-1:0]    release_run;
  logic [TIME_W-1:0]   last_fire_time;

  logic                press_latched_next;
  logic [RUN_W-1:0]    release_run_next;
  logic [TIME_W-1:0]   last_fire_time_next;

  logic [SAMPLE_W+1:0] sum_x;
  logic [SAMPLE_W+1:0] sum_y;
  logic [SAMPLE_W-1:0] avg_x;
  logic [SAMPLE_W-1:0] avg_y;
  logic [PRESS_W-1:0]  press;
  logic                contact;
  logic                release_hit;
  logic [RUN_W-1:0]    run_inc;
  logic                latch_mid;
  logic [TIME_W-1:0]   elapsed;
  logic                fire;

  // Sample averages.
  always_comb begin
    sum_x = 14'(item.raw_x_a) + 14'(item.raw_x_b) + 14'(item.raw_x_c) + 14'(item.raw_x_d);
    sum_y = 14'(item.raw_y_a) + 14'(item.raw_y_b) + 14'(item.raw_y_c) + 14'(item.raw_y_d);
    avg_x = sum_x[SAMPLE_W+1:2];
    avg_y = sum_y[SAMPLE_W+1:2];
  end

  // Pressure, contact and the release run; the latch re-arms before the fire test.
  always_comb begin
    press       = 13'(item.pressure_one) + PRESS_FULL_SCALE - 13'(item.pressure_two);
    contact     = press > cfg.press_high;
    release_hit = press < cfg.release_low;
    run_inc     = (release_run == RUN_MAX) ? release_run : release_run + 8'd1;
    release_run_next = release_hit ? run_inc : '0;
    latch_mid   = (release_hit && (run_inc >= cfg.release_samples)) ? 1'b0 : press_latched;
    elapsed     = item.time_ms - last_fire_time;
    fire        = contact && !latch_mid && (elapsed > 32'(cfg.fire_gap_ms));
    press_latched_next  = fire | latch_mid;
    last_fire_time_next = fire ? item.time_ms : last_fire_time;
  end

  // Result fields; coordinates are zero unless the sample fires.
  always_comb begin
    res.fired      = fire;
    res.pressure   = press;
    res.in_contact = contact;
    res.pos_x      = fire ? map_col(avg_y) : '0;
    res.pos_y      = fire ? map_row(avg_x) : '0;
  end

  // State moves on once per request, when its result is taken into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_latched  <= 1'b0;
      release_run    <= '0;
      last_fire_time <= '0;
    end else if (advance) begin
      press_latched  <= press_latched_next;
      release_run    <= release_run_next;
      last_fire_time <= last_fire_time_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_fire_latches: assert property (@(posedge clk) disable iff (rst)
    advance && fire |=> press_latched)
    else $error("press latch not set after a fire");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    advance && !release_hit |=> release_run == '0)
    else $error("release run not cleared by a non-release sample");

  a_fire_time: assert property (@(posedge clk) disable iff (rst)
    advance && fire |=> last_fire_time == $past(item.time_ms))
    else $error("fire time not recorded");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(press_latched) && $stable(release_run))
    else $error("qualifier state changed without a request");
`endif

endmodule

FILE: design/touch_press_qualifier_top.sv
// Top level of the touch press qualifier: input register, qualifier, output register.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: one touch sample set
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: position and pressure,
//                                                       tuser: fired
//   cfg       in         cfg_we                         cfg_index, cfg_data
//
// One request per clock cycle while m_axis is not stalled. A request is held in the
// input register, then its result in the output register. The rate is set by the single
// combinational pass between the two, where pressure, debounce state and coordinate
// multiply are evaluated. Reset clears the press latch, release run, last fire time and
// both valid flags and loads the register defaults. A stall on m_axis holds the output
// register; the input register still takes one more request before s_axis_tready drops.
module touch_press_qualifier_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pressure_one, pressure_two, raw_x_a, raw_x_b, raw_x_c, raw_x_d,
  // raw_y_a, raw_y_b, raw_y_c, raw_y_d, time_ms
  input  logic [tpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pos_x, pos_y, in_contact, pressure, one zero pad bit
  output logic [tpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // fired
  output logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_we,
  input  logic [tpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpq_pkg::*;

  cfg_t     cfg;
  logic     s1_valid;
  in_item_t s1_item;
  logic     out_valid;
  res_t     out_res;
  res_t     res;
  logic     out_free;
  logic     advance;

  // Handshake: the input register empties whenever the output register can load.
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  tpq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpq_qualify u_qualify (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (s1_item),
    .advance (advance),
    .res     (res)
  );

  // Valid flags of the two register stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item <= in_item_t'(s_axis_tdata);
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.pressure, out_res.in_contact,
                          out_res.pos_y, out_res.pos_x};
  assign m_axis_tuser  = out_res.fired;

`ifndef NO_ASSERTIONS
  a_fire_contact: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.fired |-> out_res.in_contact)
    else $error("fired result without contact");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.fired |-> out_res.pos_x == '0 && out_res.pos_y == '0)
    else $error("position set on a result that did not fire");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_res.pos_x <= COL_MAX && out_res.pos_y <= ROW_MAX)
    else $error("position outside the screen");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("request lost between input and output registers");
`endif

endmodule
